@@ rtl/wide_char_to_codepage_converter_defines.svh @@
// ----------------------------------------------------------------------------
// Wide-char converter assertion macros
// Shared concurrent-check shorthands, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef WIDE_CHAR_TO_CODEPAGE_CONVERTER_DEFINES_SVH
`define WIDE_CHAR_TO_CODEPAGE_CONVERTER_DEFINES_SVH

// check that is off while rst is high
`define WCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also holds during reset
`define WCC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Wide-char converter package
// Item types, codes and sizes shared by the converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package wcc_pkg;

  localparam int WORD_ENTRIES_DEFAULT = 8192;
  localparam int BLOCK_DEPTH = 256;
  localparam int BLOCK_W = 13;
  localparam int ADDR_W = 17;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [1:0] MODE_BLOCK_WR = 2'd0;
  localparam logic [1:0] MODE_WORD_WR = 2'd1;
  localparam logic [1:0] MODE_CONVERT = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic CFG_DOUBLE_BYTE = 1'b0;
  localparam logic CFG_CAPACITY = 1'b1;

  localparam logic [15:0] LEAD_MASK = 16'hff00;
  localparam logic [15:0] TRAIL_MASK = 16'h00ff;
  localparam logic [16:0] LEN_MAX = 17'h1ffff;

  typedef struct packed {
    logic [1:0] mode;
    logic [12:0] table_index;
    logic [15:0] table_word;
    logic [15:0] code_unit;
    logic end_of_string;
  } in_item_t;

  typedef struct packed {
    logic kind;
    logic [7:0] out_byte;
    logic [16:0] length;
    logic overflow;
    logic last;
  } out_item_t;

  typedef struct packed {
    logic double_byte_page;
    logic [15:0] dest_capacity;
  } cfg_t;

  typedef struct packed {
    logic [15:0] word;
    logic eos;
  } conv_item_t;

endpackage

`default_nettype wire

@@ rtl/wcc_front.sv @@
// ----------------------------------------------------------------------------
// Wide-char converter front end
// Accepts items, performs table writes and the two-level table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module wcc_front #(
  parameter int WORD_ENTRIES = wcc_pkg::WORD_ENTRIES_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire wcc_pkg::in_item_t        in_item,
  input  wire logic [wcc_pkg::QCNT_W-1:0] q_count,
  output logic                          push,
  output wcc_pkg::conv_item_t           push_item
);
  import wcc_pkg::*;

  localparam int IDX_W = $clog2(WORD_ENTRIES);
  localparam logic [ADDR_W-1:0] WORD_LIMIT = ADDR_W'(WORD_ENTRIES);

  logic [BLOCK_W-1:0] block_mem [BLOCK_DEPTH];
  logic [15:0] word_mem [WORD_ENTRIES];

  logic accept;
  logic block_we;
  logic word_we;
  logic [ADDR_W-1:0] word_wr_addr;
  logic [ADDR_W-1:0] word_rd_addr;
  logic [QCNT_W:0] used;

  logic s1_valid;
  logic [7:0] s1_lo;
  logic s1_eos;
  logic [BLOCK_W-1:0] block_rd;

  logic s2_valid;
  logic s2_eos;
  logic s2_oor;
  logic [15:0] word_rd;

  // every convert in flight holds a queue slot
  assign used = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid) + (QCNT_W+1)'(s2_valid);
  assign in_ready = used < (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept = in_valid && in_ready;

  assign block_we = accept && (in_item.mode == MODE_BLOCK_WR) &&
                    (in_item.table_index < 13'(BLOCK_DEPTH));
  assign word_wr_addr = ADDR_W'(in_item.table_index);
  assign word_we = accept && (in_item.mode == MODE_WORD_WR) && (word_wr_addr < WORD_LIMIT);
  assign word_rd_addr = ADDR_W'(block_rd) + ADDR_W'(s1_lo);

  always_ff @(posedge clk) begin
    if (block_we) begin
      block_mem[in_item.table_index[7:0]] <= in_item.table_word[BLOCK_W-1:0];
    end
    block_rd <= block_mem[in_item.code_unit[15:8]];
  end

  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[word_wr_addr[IDX_W-1:0]] <= in_item.table_word;
    end
    word_rd <= word_mem[word_rd_addr[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && (in_item.mode == MODE_CONVERT);
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_lo <= in_item.code_unit[7:0];
    s1_eos <= in_item.end_of_string;
    s2_eos <= s1_eos;
    s2_oor <= word_rd_addr >= WORD_LIMIT;
  end

  assign push = s2_valid;
  assign push_item.word = s2_oor ? 16'h0000 : word_rd;
  assign push_item.eos = s2_eos;

endmodule

`default_nettype wire

@@ rtl/wcc_queue.sv @@
// ----------------------------------------------------------------------------
// Wide-char converter queue
// Short FIFO of looked-up words between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wcc_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire wcc_pkg::conv_item_t        push_item,
  input  wire logic                       pop,
  output logic                            q_valid,
  output wcc_pkg::conv_item_t             q_item,
  output logic [wcc_pkg::QCNT_W-1:0]      q_count
);
  import wcc_pkg::*;

  conv_item_t q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] q_count_next;

  always_comb begin
    q_count_next = q_count;
    if (push && !pop) begin
      q_count_next = q_count + QCNT_W'(1);
    end else if (pop && !push) begin
      q_count_next = q_count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      q_count <= q_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= push_item;
    end
  end

  assign q_valid = q_count != '0;
  assign q_item = q_mem[rd_ptr];

endmodule

`default_nettype wire

@@ rtl/wcc_back.sv @@
// ----------------------------------------------------------------------------
// Wide-char converter back end
// Tracks the string budget and count, and emits bytes and summaries.
// ----------------------------------------------------------------------------
`default_nettype none
`include "wide_char_to_codepage_converter_defines.svh"

module wcc_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wcc_pkg::cfg_t       cfg,
  input  wire logic                q_valid,
  input  wire wcc_pkg::conv_item_t q_item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wcc_pkg::out_item_t       out_item
);
  import wcc_pkg::*;

  localparam int P_SUM = 0;
  localparam int P_TRAIL = 1;
  localparam int P_LEAD = 2;

  logic [15:0] budget_left;
  logic [16:0] length_count;
  logic stopped;
  logic overflow_seen;
  logic at_string_start;
  logic count_only;

  logic [2:0] pend;
  logic [7:0] lead_byte;
  logic [7:0] trail_byte;
  logic [16:0] sum_len;
  logic sum_ovf;

  logic load;
  logic [2:0] pend_after;
  out_item_t res;

  logic [15:0] bl;
  logic co;
  logic [16:0] len;
  logic st;
  logic ov;
  logic pair;
  logic [1:0] need;
  logic [17:0] len_sum;
  logic [16:0] len_sat;
  logic [15:0] budget_left_next;
  logic [16:0] length_count_next;
  logic stopped_next;
  logic overflow_seen_next;
  logic emit_lead;
  logic emit_trail;

  // next result out of the pending set: lead, trail, summary
  always_comb begin
    load = (pend != '0) && (!out_valid || out_ready);
    pend_after = pend;
    res = '0;
    if (pend[P_LEAD]) begin
      res.kind = KIND_BYTE;
      res.out_byte = lead_byte;
      pend_after[P_LEAD] = 1'b0;
    end else if (pend[P_TRAIL]) begin
      res.kind = KIND_BYTE;
      res.out_byte = trail_byte;
      pend_after[P_TRAIL] = 1'b0;
    end else begin
      res.kind = KIND_SUMMARY;
      res.length = sum_len;
      res.overflow = sum_ovf;
      pend_after[P_SUM] = 1'b0;
    end
    res.last = pend_after == '0;
    if (!load) begin
      pend_after = pend;
    end
    pop = q_valid && (pend_after == '0);
  end

  always_comb begin
    bl = at_string_start ? cfg.dest_capacity : budget_left;
    co = at_string_start ? (cfg.dest_capacity == '0) : count_only;
    len = at_string_start ? '0 : length_count;
    st = at_string_start ? 1'b0 : stopped;
    ov = at_string_start ? 1'b0 : overflow_seen;
    pair = cfg.double_byte_page && ((q_item.word & LEAD_MASK) != '0);
    need = pair ? 2'd2 : 2'd1;
    len_sum = 18'(len) + 18'(need);
    len_sat = (len_sum > 18'(LEN_MAX)) ? LEN_MAX : len_sum[16:0];

    budget_left_next = bl;
    length_count_next = len;
    stopped_next = st;
    overflow_seen_next = ov;
    emit_lead = 1'b0;
    emit_trail = 1'b0;
    if (co) begin
      length_count_next = len_sat;
    end else if (!st) begin
      if (bl >= 16'(need)) begin
        emit_lead = pair;
        emit_trail = 1'b1;
        budget_left_next = bl - 16'(need);
        length_count_next = len_sat;
      end else begin
        stopped_next = 1'b1;
        overflow_seen_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget_left <= '0;
      length_count <= '0;
      stopped <= 1'b0;
      overflow_seen <= 1'b0;
      at_string_start <= 1'b1;
      count_only <= 1'b0;
      pend <= '0;
    end else if (pop) begin
      budget_left <= budget_left_next;
      length_count <= length_count_next;
      stopped <= stopped_next;
      overflow_seen <= overflow_seen_next;
      at_string_start <= q_item.eos;
      count_only <= co;
      pend <= {emit_lead, emit_trail, q_item.eos};
    end else if (load) begin
      pend <= pend_after;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      lead_byte <= q_item.word[15:8];
      trail_byte <= 8'(q_item.word & TRAIL_MASK);
      sum_len <= length_count_next;
      sum_ovf <= overflow_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item <= res;
    end
  end

  `WCC_ASSERT_ALWAYS(a_sum_last, out_valid && out_item.kind == KIND_SUMMARY |-> out_item.last, "summary not last")
  `WCC_ASSERT(a_byte_clean, out_valid && out_item.kind == KIND_BYTE |-> out_item.length == '0 && !out_item.overflow, "byte item carries count")
  `WCC_ASSERT(a_burst, out_valid && out_ready && !out_item.last |=> out_valid, "gap inside result burst")

endmodule

`default_nettype wire

@@ rtl/wide_char_to_codepage_converter.sv @@
// ----------------------------------------------------------------------------
// Wide-char to code-page converter
// Two-level table conversion of 16-bit code units into code-page bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_item): table writes and code units.
//   Table writes give no result; a convert gives 0 to 2 bytes and, on the
//   last unit of a string, a summary with the byte count and overflow flag.
// Output channel (out_valid/out_ready/out_item): one result per cycle while
//   out_ready is high; the item's last flag marks its final result.
// Config port (cfg_wr_en/cfg_addr/cfg_wdata): page type and byte budget, to be
//   written by the user only while idle; the block does not enforce this.
// Path from the edge that accepts a convert to out_valid of its first result:
//   block table read at the accepting edge, then word table read, queue,
//   pending stage, output register.
// Throughput: one item per cycle while in_ready is high, bounded by the output
//   port at one result per cycle; a pair plus summary gives three results there.
// A 4-entry queue decouples the lookup pipe from the emitter; in_ready drops
//   when the queue and the lookup pipe together hold 4 converts.
// Reset clears control state and starts a new string; table contents stay
//   undefined until written. A stalled receiver backs up the queue and then
//   the input.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_char_to_codepage_converter #(
  parameter int WORD_ENTRIES = wcc_pkg::WORD_ENTRIES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire wcc_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output wcc_pkg::out_item_t     out_item,
  input  wire logic              cfg_wr_en,
  input  wire logic              cfg_addr,
  input  wire logic [15:0]       cfg_wdata
);
  import wcc_pkg::*;

  cfg_t cfg;
  logic push;
  conv_item_t push_item;
  logic pop;
  logic q_valid;
  conv_item_t q_item;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_DOUBLE_BYTE: cfg.double_byte_page <= cfg_wdata[0];
        CFG_CAPACITY:    cfg.dest_capacity <= cfg_wdata;
        default:         cfg <= cfg;
      endcase
    end
  end

  wcc_front #(
    .WORD_ENTRIES(WORD_ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .q_count   (q_count),
    .push      (push),
    .push_item (push_item)
  );

  wcc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_count   (q_count)
  );

  wcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

@@ sim/tb_wide_char_to_codepage_converter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wide-char to code-page converter testbench
// Loads the block and word tables, then converts strings of code units on
// single- and double-byte pages with count-only, tight and large byte budgets.
// A scoreboard model predicts every byte and summary item; random gaps and
// stalls on both channels shake the handshakes.
// ----------------------------------------------------------------------------
module tb_wide_char_to_codepage_converter;
  import wcc_pkg::*;

  localparam int WORDS = WORD_ENTRIES_DEFAULT;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [15:0] FALLBACK_UNIT = 16'hff80;
  localparam int SETTLE_CYCLES = 12;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_ITEMS = 90;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en;
  logic cfg_addr;
  logic [15:0] cfg_wdata;

  // converter model state
  logic [BLOCK_W-1:0] blk_offset [0:BLOCK_DEPTH-1];
  bit blk_ok [0:BLOCK_DEPTH-1];
  logic [15:0] code_word [0:WORDS-1];
  bit word_ok [0:WORDS-1];
  logic [7:0] mapped_hi [$];
  logic [15:0] good_units [$];
  bit dbl_reg = 1'b0;
  logic [15:0] cap_reg = 16'd0;
  int budget = 0;
  int len_acc = 0;
  bit halted = 1'b0;
  bit ovf_flag = 1'b0;
  bit at_start = 1'b1;
  bit count_only = 1'b0;

  out_item_t expected_results [$];

  int mismatches = 0;
  int items_accepted = 0;
  int useful_items = 0;
  int bytes_seen = 0;
  int summaries_seen = 0;
  int overflow_summaries = 0;
  int cycle_count = 0;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int rx_hold = 0;

  wide_char_to_codepage_converter u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int idle_len();
    if ($urandom_range(0, 19) < 16) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int next_gap();
    if (tx_burst || $urandom_range(0, 9) < 5) return 0;
    return idle_len();
  endfunction

  function automatic string fmt_result(out_item_t r);
    return $sformatf("kind=%0d byte=%02h len=%0d ovf=%0d last=%0d",
                     r.kind, r.out_byte, r.length, r.overflow, r.last);
  endfunction

  // expected results of one accepted item
  function automatic void predict_item(in_item_t it);
    logic [16:0] addr;
    logic [15:0] w;
    logic pair;
    int need;
    int np;
    out_item_t pend [3];
    np = 0;
    case (it.mode)
      MODE_BLOCK_WR: begin
        if (it.table_index <= 13'd255) begin
          blk_offset[it.table_index[7:0]] = it.table_word[BLOCK_W-1:0];
          if (!blk_ok[it.table_index[7:0]]) mapped_hi.push_back(it.table_index[7:0]);
          blk_ok[it.table_index[7:0]] = 1'b1;
          useful_items++;
        end
      end
      MODE_WORD_WR: begin
        code_word[it.table_index] = it.table_word;
        word_ok[it.table_index] = 1'b1;
        useful_items++;
      end
      MODE_CONVERT: begin
        useful_items++;
        if (at_start) begin
          budget = int'(cap_reg);
          count_only = (cap_reg == 16'd0);
          len_acc = 0;
          halted = 1'b0;
          ovf_flag = 1'b0;
          at_start = 1'b0;
        end
        addr = {4'd0, blk_offset[it.code_unit[15:8]]} + {9'd0, it.code_unit[7:0]};
        w = (addr >= WORDS) ? 16'h0000 : code_word[addr[12:0]];
        pair = dbl_reg && ((w & LEAD_MASK) != 16'h0000);
        need = pair ? 2 : 1;
        if (count_only) begin
          len_acc += need;
        end else if (!halted) begin
          if (budget >= need) begin
            if (pair) begin
              pend[np] = '0;
              pend[np].kind = KIND_BYTE;
              pend[np].out_byte = w[15:8];
              np++;
            end
            pend[np] = '0;
            pend[np].kind = KIND_BYTE;
            pend[np].out_byte = w[7:0];
            np++;
            budget -= need;
            len_acc += need;
          end else begin
            halted = 1'b1;
            ovf_flag = 1'b1;
          end
        end
        if (len_acc > int'(LEN_MAX)) len_acc = int'(LEN_MAX);
        if (it.end_of_string) begin
          pend[np] = '0;
          pend[np].kind = KIND_SUMMARY;
          pend[np].length = 17'(len_acc);
          pend[np].overflow = ovf_flag;
          np++;
          at_start = 1'b1;
        end
      end
      default: ;
    endcase
    if (np > 0) pend[np-1].last = 1'b1;
    for (int i = 0; i < np; i++) expected_results.push_back(pend[i]);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    it.mode = MODE_CONVERT;
    it.table_index = 13'($urandom);
    it.table_word = 16'($urandom);
    it.code_unit = 16'($urandom);
    it.end_of_string = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // code units whose lookup touches written entries or runs past the word table, else a fallback unit
  function automatic logic [15:0] pick_code_unit();
    logic [15:0] cu;
    logic [16:0] addr;
    for (int tries = 0; tries < 40; tries++) begin
      if (tries < 8 && good_units.size() > 0 && $urandom_range(0, 1))
        cu = good_units[$urandom_range(0, good_units.size() - 1)];
      else begin
        cu[15:8] = mapped_hi[$urandom_range(0, mapped_hi.size() - 1)];
        cu[7:0] = 8'($urandom);
      end
      addr = {4'd0, blk_offset[cu[15:8]]} + {9'd0, cu[7:0]};
      if (blk_ok[cu[15:8]] && (addr >= WORDS || word_ok[addr[12:0]])) return cu;
    end
    return FALLBACK_UNIT;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    @(negedge clk);
    gap = next_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    items_accepted++;
    predict_item(it);
  endtask

  task automatic send_block(logic [12:0] idx, logic [15:0] val);
    in_item_t it;
    it = rand_item();
    it.mode = MODE_BLOCK_WR;
    it.table_index = idx;
    it.table_word = val;
    send_item(it);
  endtask

  task automatic send_word(logic [12:0] idx, logic [15:0] val);
    in_item_t it;
    it = rand_item();
    it.mode = MODE_WORD_WR;
    it.table_index = idx;
    it.table_word = val;
    send_item(it);
  endtask

  task automatic send_unit(logic [15:0] cu, logic eos);
    in_item_t it;
    it = rand_item();
    it.code_unit = cu;
    it.end_of_string = eos;
    send_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(bit dbl, logic [15:0] cap);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_addr = CFG_DOUBLE_BYTE;
    cfg_wdata = {15'd0, dbl};
    @(negedge clk);
    cfg_addr = CFG_CAPACITY;
    cfg_wdata = cap;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    dbl_reg = dbl;
    cap_reg = cap;
  endtask

  task automatic test_table_load();
    send_block(13'd0, 16'h0000);
    send_block(13'd255, 16'hffff);   // masks to the top offset
    send_block(13'h12, 16'he100);
    send_word(13'h41, 16'h0041);
    send_word(13'h42, 16'h8140);
    send_word(13'd8191, 16'hffff);
    send_word(13'h1ff, 16'h00ff);
    good_units.push_back(16'h0041);
    good_units.push_back(16'h0042);
    good_units.push_back(16'h12ff);
    good_units.push_back(16'hff00);
  endtask

  task automatic test_ignored_items();
    in_item_t it;
    it = rand_item();
    it.mode = MODE_RESERVED;
    send_item(it);
    send_block(13'd256, 16'h1234);
    send_block(13'd8191, 16'h0aaa);
  endtask

  task automatic test_single_byte_page();
    set_config(1'b0, 16'hffff);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'hff00, 1'b0);
    send_unit(16'hffff, 1'b0);        // lookup past the word table
    send_unit(16'h12ff, 1'b1);
  endtask

  task automatic test_double_byte_page();
    set_config(1'b1, 16'd8);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hff00, 1'b1);        // pair plus summary
  endtask

  task automatic test_count_only();
    set_config(1'b1, 16'd0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h12ff, 1'b1);
  endtask

  task automatic test_capacity_limits();
    set_config(1'b1, 16'd1);
    send_unit(16'h0042, 1'b0);        // pair never split
    send_unit(16'h0041, 1'b1);
    set_config(1'b1, 16'd3);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0041, 1'b1);
  endtask

  task automatic test_register_change_mid_string();
    set_config(1'b0, 16'd4);
    send_unit(16'h0042, 1'b0);
    set_config(1'b1, 16'd0);          // page now, budget at next string
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0042, 1'b1);
    send_unit(16'h0041, 1'b1);
  endtask

  task automatic send_string(int n, bit close);
    for (int i = 0; i < n; i++) send_unit(pick_code_unit(), close && (i == n - 1));
  endtask

  task automatic random_table_update();
    in_item_t it;
    logic [7:0] hb;
    logic [12:0] off;
    logic [2:0] junk;
    int lb;
    hb = 8'($urandom_range(1, 254));
    off = 13'($urandom_range(0, 8191));
    junk = 3'($urandom_range(0, 7));
    it = rand_item();
    it.mode = MODE_BLOCK_WR;
    it.table_word = {junk, off};
    if ($urandom_range(0, 4) == 0) it.table_index = 13'($urandom_range(256, 8191));
    else it.table_index = {5'd0, hb};
    send_item(it);
    repeat ($urandom_range(1, 3)) begin
      it = rand_item();
      it.mode = MODE_WORD_WR;
      lb = $urandom_range(0, 255);
      if ($urandom_range(0, 3) != 0 && off + lb < WORDS) begin
        it.table_index = 13'(off + lb);
        good_units.push_back({hb, lb[7:0]});
      end
      if ($urandom_range(0, 1)) it.table_word = 16'($urandom_range(0, 255));
      send_item(it);
    end
  endtask

  task automatic test_random_traffic();
    int target;
    int pick;
    logic [15:0] cap;
    in_item_t it;
    target = useful_items + RANDOM_ITEMS;
    while (useful_items < target) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0: cap = 16'd0;
        1: cap = 16'd1;
        2: cap = 16'd2;
        3: cap = 16'hffff;
        default: cap = 16'($urandom_range(3, 12));
      endcase
      set_config(1'($urandom_range(0, 1)), cap);
      tx_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 6)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          send_string($urandom_range(1, 6), 1'b1);
        end else if (pick < 9) begin
          random_table_update();
        end else if ($urandom_range(0, 1)) begin
          it = rand_item();
          it.mode = MODE_RESERVED;
          send_item(it);
        end else begin
          send_string($urandom_range(1, 3), 1'b0);   // left open
        end
      end
    end
    tx_burst = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!rx_burst && $urandom_range(0, 3) == 0) rx_hold = idle_len();
    end
    if ($urandom_range(0, 149) == 0) rx_burst = !rx_burst;
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with nothing expected: %s", $time, fmt_result(out_item));
      end else begin
        want = expected_results.pop_front();
        if (out_item.kind !== want.kind || out_item.out_byte !== want.out_byte ||
            out_item.length !== want.length || out_item.overflow !== want.overflow ||
            out_item.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] mismatch: expected %s, got %s", $time, fmt_result(want),
                     fmt_result(out_item));
        end else if (want.kind == KIND_SUMMARY) begin
          summaries_seen++;
          if (want.overflow) overflow_summaries++;
        end else begin
          bytes_seen++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = CFG_DOUBLE_BYTE;
    cfg_wdata = 16'd0;
    for (int i = 0; i < BLOCK_DEPTH; i++) begin
      blk_offset[i] = '0;
      blk_ok[i] = 1'b0;
    end
    for (int i = 0; i < WORDS; i++) begin
      code_word[i] = '0;
      word_ok[i] = 1'b0;
    end
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_table_load();
    test_ignored_items();
    test_single_byte_page();
    test_double_byte_page();
    test_count_only();
    test_capacity_limits();
    test_register_change_mid_string();
    test_random_traffic();
    wait_idle();

    $display("accepted %0d items (%0d table writes and converts) over %0d cycles",
             items_accepted, useful_items, cycle_count);
    $display("matched %0d bytes and %0d summaries, %0d of them overflowed; %0d mismatches",
             bytes_seen, summaries_seen, overflow_summaries, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
